// ===== hdl/assert_macros.svh =====
// assertion macros shared by the timer queue rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/stq_pkg.sv =====
// shared types and constants of the sorted timer event queue
// no dependencies
package stq_pkg;

    localparam int NOW_W      = 48;
    localparam int LIMIT_W    = NOW_W + 1;
    localparam int DELAY_W    = 32;
    localparam int TAG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int WINDOW_W   = 24;
    localparam int MS_W       = 10;
    localparam int PROD_W     = DELAY_W + MS_W;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W = 4;

    localparam logic [MS_W-1:0]     US_PER_MS    = 10'd1000;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd500000;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // register index decoded from paddr[2]
    localparam logic REG_EARLY_WINDOW = 1'b0;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_INS  = 6'b001000,
        S_CHK  = 6'b010000,
        S_FIRE = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;  // latch input item, advance clock on a tick
        logic mul;   // delay times microseconds per millisecond
        logic add;   // deadline = now + product
        logic ins;   // sorted insert (or drop) and schedule result
        logic chk;   // window limit, clear burst count
        logic fire;  // emit head and pop
    } t_dp_cmd;

    typedef struct packed {
        logic due;       // head entry deadline reached
        logic more;      // another entry follows in this burst
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

// ===== hdl/stq_ctrl.sv =====
// controller state machine of the sorted timer event queue
// depends on stq_pkg
module stq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_cmd,
    output logic               o_ready,
    input  stq_pkg::t_dp_sts   i_sts,
    output stq_pkg::t_dp_cmd   o_cmd
);

    stq_pkg::t_state r_state;
    stq_pkg::t_state n_state;
    logic            w_accept;

    assign o_ready  = (r_state == stq_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.load = w_accept;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd == stq_pkg::CMD_TICK) ? stq_pkg::S_CHK : stq_pkg::S_MUL;
                end
            end
            stq_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = stq_pkg::S_ADD;
            end
            stq_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = stq_pkg::S_INS;
            end
            stq_pkg::S_INS: begin
                if (i_sts.out_free) begin
                    o_cmd.ins = 1'b1;
                    n_state   = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.due ? stq_pkg::S_FIRE : stq_pkg::S_IDLE;
            end
            stq_pkg::S_FIRE: begin
                if (i_sts.out_free) begin
                    o_cmd.fire = 1'b1;
                    if (!i_sts.more) begin
                        n_state = stq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = stq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/stq_datapath.sv =====
// datapath: clock, deadline arithmetic, sorted cell row and result register
// depends on stq_pkg
module stq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stq_pkg::t_dp_cmd              i_cmd,
    output stq_pkg::t_dp_sts              o_sts,
    output logic [CNT_W-1:0]              o_count,
    input  logic                          i_in_cmd,
    input  logic [stq_pkg::DELAY_W-1:0]   i_delay_ms,
    input  logic [stq_pkg::TAG_W-1:0]     i_tag,
    input  logic [stq_pkg::WINDOW_W-1:0]  i_early_window,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stq_pkg::KIND_W-1:0]    o_kind,
    output logic [stq_pkg::TAG_W-1:0]     o_tag,
    output logic                          o_last
);

    logic [stq_pkg::NOW_W-1:0]      r_now;
    logic [stq_pkg::DELAY_W-1:0]    r_delay;
    logic [stq_pkg::TAG_W-1:0]      r_tag;
    logic [stq_pkg::PROD_W-1:0]     r_prod;
    logic [stq_pkg::NOW_W-1:0]      r_dl;
    logic [stq_pkg::LIMIT_W-1:0]    r_limit;
    logic [CNT_W-1:0]               r_count;
    logic [stq_pkg::FIRE_CNT_W-1:0] r_fire_cnt;

    logic [stq_pkg::NOW_W-1:0] r_cell_dl  [QUEUE_DEPTH];
    logic [stq_pkg::TAG_W-1:0] r_cell_tag [QUEUE_DEPTH];

    logic                   r_out_valid;
    logic [stq_pkg::KIND_W-1:0] r_out_kind;
    logic [stq_pkg::TAG_W-1:0]  r_out_tag;
    logic                   r_out_last;

    logic [QUEUE_DEPTH-1:0] w_le;
    logic                   w_full;
    logic                   w_do_ins;

    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_do_ins = i_cmd.ins && !w_full;

    // occupied cells whose deadline is not later than the new one; a prefix
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_cell_dl[i] <= r_dl);
        end
    end

    assign o_sts.due      = (r_count != '0) && (r_cell_dl[0] <= r_now);
    assign o_sts.more     = (r_count > CNT_W'(1))
                            && (r_fire_cnt != stq_pkg::FIRE_CNT_W'(stq_pkg::MAX_RESULTS - 1))
                            && ({1'b0, r_cell_dl[1]} < r_limit);
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_count        = r_count;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (i_in_cmd == stq_pkg::CMD_TICK)) begin
                r_now <= r_now + stq_pkg::NOW_W'(1);
            end
            if (w_do_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.fire) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.ins || i_cmd.fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delay <= i_delay_ms;
            r_tag   <= i_tag;
        end
        if (i_cmd.mul) begin
            r_prod <= {stq_pkg::MS_W'(0), r_delay}
                      * {stq_pkg::DELAY_W'(0), stq_pkg::US_PER_MS};
        end
        if (i_cmd.add) begin
            r_dl <= r_now + {(stq_pkg::NOW_W - stq_pkg::PROD_W)'(0), r_prod};
        end
        if (i_cmd.chk) begin
            r_limit    <= {1'b0, r_now} + stq_pkg::LIMIT_W'(i_early_window);
            r_fire_cnt <= '0;
        end else if (i_cmd.fire) begin
            r_fire_cnt <= r_fire_cnt + stq_pkg::FIRE_CNT_W'(1);
        end
        if (i_cmd.ins) begin
            r_out_kind <= w_full ? stq_pkg::KIND_DROPPED : stq_pkg::KIND_SCHEDULED;
            r_out_tag  <= r_tag;
            r_out_last <= 1'b1;
        end else if (i_cmd.fire) begin
            r_out_kind <= stq_pkg::KIND_FIRED;
            r_out_tag  <= r_cell_tag[0];
            r_out_last <= !o_sts.more;
        end
    end

    // cell row: each cell keeps, takes the new entry, shifts up on insert
    // or shifts down on pop
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic w_take_new;
        if (g == 0) begin : g_head
            assign w_take_new = !w_le[0];
        end else begin : g_body
            assign w_take_new = !w_le[g] && w_le[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_do_ins) begin
                if (w_take_new) begin
                    r_cell_dl[g]  <= r_dl;
                    r_cell_tag[g] <= r_tag;
                end else if (!w_le[g]) begin
                    if (g > 0) begin
                        r_cell_dl[g]  <= r_cell_dl[(g > 0) ? g - 1 : 0];
                        r_cell_tag[g] <= r_cell_tag[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (i_cmd.fire) begin
                if (g < QUEUE_DEPTH - 1) begin
                    r_cell_dl[g]  <= r_cell_dl[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    r_cell_tag[g] <= r_cell_tag[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_tag   = r_out_tag;
    assign o_last  = r_out_last;

endmodule

// ===== hdl/sorted_timer_event_queue_unit.sv =====
// top level of the sorted timer event queue: stream ports, apb register
// depends on stq_pkg, stq_ctrl, stq_datapath and assert_macros.svh
//
// usage:
//   input stream (s_*): tuser = cmd (0 schedule, 1 one-microsecond tick),
//   tdata = delay_ms [31:0], tag [47:32]. output stream (m_*): tuser = kind
//   (0 scheduled, 1 dropped on full queue, 2 fired), tdata = tag, tlast marks
//   the final result of an input item.
//   a schedule item gives one result after its steps (multiply
//   by 1000, add to the clock, parallel compare-and-shift insert);
//   the next item is accepted in the cycle after the insert, so a new item
//   waits until the last schedule is through.
//   a tick advances the clock at acceptance, the next cycle checks the head
//   entry and forms now + early window; a tick with nothing due ends there,
//   otherwise one fired result leaves per cycle (up to 16) while the output
//   is not stalled, each pop being one down-shift of the cell row. the burst
//   sets the tick's length.
//   results sit in one output register; the next item can be accepted while
//   it waits. a stalled receiver holds the controller in the insert or fire
//   step until the register frees up, nothing is lost.
//   reset empties the queue, clears the clock and sets the early window to
//   500000 us. write early_window_us at byte address 0 only while idle.
`include "assert_macros.svh"

module sorted_timer_event_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // delay_ms [31:0], tag [47:32]
    input  logic        s_tuser,   // cmd [0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tag_res [15:0]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    stq_pkg::t_dp_cmd                w_cmd;
    stq_pkg::t_dp_sts                w_sts;
    logic [CNT_W-1:0]                w_count;
    logic [stq_pkg::WINDOW_W-1:0]    r_early_window;
    logic                            w_reg_sel;
    logic                            w_fired_out;

    // register decode on word address
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == stq_pkg::REG_EARLY_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early_window <= stq_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_early_window <= pwdata[stq_pkg::WINDOW_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? {8'd0, r_early_window} : 32'd0;

    stq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_cmd   (s_tuser),
        .o_ready (s_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    stq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_count        (w_count),
        .i_in_cmd       (s_tuser),
        .i_delay_ms     (s_tdata[31:0]),
        .i_tag          (s_tdata[47:32]),
        .i_early_window (r_early_window),
        .o_valid        (m_tvalid),
        .i_ready        (m_tready),
        .o_kind         (m_tuser),
        .o_tag          (m_tdata),
        .o_last         (m_tlast)
    );

    // output register holds a fired result
    assign w_fired_out = m_tvalid && (m_tuser == stq_pkg::KIND_FIRED);

    // occupancy never goes past the cell row
    `STQ_ASSERT(a_count_bound, i_clk, i_rst_n, w_count <= CNT_W'(QUEUE_DEPTH), "count above depth")
    // a pop only happens on an occupied queue
    `STQ_ASSERT(a_fire_nonempty, i_clk, i_rst_n, w_cmd.fire |-> (w_count != '0), "pop of empty queue")
    // the final fired item of a burst returns the controller to idle
    `STQ_ASSERT_NEXT(a_burst_end, i_clk, i_rst_n, w_cmd.fire && !w_sts.more, s_tready, "burst end not idle")
    // a pop always loads the output register as a fired result
    `STQ_ASSERT_NEXT(a_fire_out, i_clk, i_rst_n, w_cmd.fire, w_fired_out, "fired item missing")

endmodule
